// ----- rtl/c128b_pkg.sv -----
`timescale 1ns / 1ps

package c128b_pkg;

    localparam int SYM_W  = 7;
    localparam int PROD_W = 14;
    localparam int CHAR_W = 8;
    localparam int OUT_W  = 32;

    localparam int C128B_QUEUE_DEPTH = 4;

    localparam logic [SYM_W-1:0]  CHECK_MOD   = 7'd103;
    localparam logic [SYM_W-1:0]  START_B     = 7'd104;
    localparam logic [SYM_W-1:0]  STOP_VAL    = 7'd106;
    localparam logic [CHAR_W-1:0] FIRST_VALID = 8'd32;
    localparam logic [CHAR_W-1:0] LAST_VALID  = 8'd127;

    // start b leaves the checksum at start value modulo the check modulus
    localparam logic [SYM_W-1:0]  START_SUM   = START_B - CHECK_MOD;

    localparam int PATTERN_COUNT = 106;

    // one nibble per element, bar a in the top nibble down to space c
    localparam logic [23:0] PATTERN [PATTERN_COUNT] = '{
        24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222,
        24'h122213, 24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212,
        24'h112232, 24'h122132, 24'h122231, 24'h113222, 24'h123122, 24'h123221,
        24'h223211, 24'h221132, 24'h221231, 24'h213212, 24'h223112, 24'h312131,
        24'h311222, 24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
        24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123, 24'h131321,
        24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
        24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121,
        24'h313121, 24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131,
        24'h311123, 24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
        24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422, 24'h121124,
        24'h121421, 24'h141122, 24'h141221, 24'h112214, 24'h112412, 24'h122114,
        24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114, 24'h413111,
        24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
        24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
        24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113,
        24'h114311, 24'h411113, 24'h411311, 24'h113141, 24'h114131, 24'h311141,
        24'h411131, 24'h211412, 24'h211214, 24'h211232
    };

    // seven elements, bar a first
    localparam logic [27:0] STOP_PATTERN = 28'h2331112;

    typedef struct packed {
        logic              bad;
        logic              start;
        logic              last;
        logic [SYM_W-1:0]  value;
        logic [PROD_W-1:0] prod;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_DATA,
        PH_CHECK,
        PH_STOP
    } t_phase;

    typedef struct packed {
        logic [2:0] bar_d;
        logic [2:0] space_c;
        logic [2:0] bar_c;
        logic [2:0] space_b;
        logic [2:0] bar_b;
        logic [2:0] space_a;
        logic [2:0] bar_a;
    } t_widths;

    function automatic t_widths symbol_widths(input logic [SYM_W-1:0] value);
        logic [23:0] p;
        t_widths     w;
        p = '0;
        w = '0;
        if (value == STOP_VAL) begin
            w.bar_a   = STOP_PATTERN[26:24];
            w.space_a = STOP_PATTERN[22:20];
            w.bar_b   = STOP_PATTERN[18:16];
            w.space_b = STOP_PATTERN[14:12];
            w.bar_c   = STOP_PATTERN[10:8];
            w.space_c = STOP_PATTERN[6:4];
            w.bar_d   = STOP_PATTERN[2:0];
        end else if (value < SYM_W'(PATTERN_COUNT)) begin
            p         = PATTERN[value];
            w.bar_a   = p[22:20];
            w.space_a = p[18:16];
            w.bar_b   = p[14:12];
            w.space_b = p[10:8];
            w.bar_c   = p[6:4];
            w.space_c = p[2:0];
        end
        return w;
    endfunction

endpackage

// ----- rtl/c128b_front.sv -----
`timescale 1ns / 1ps

module c128b_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [c128b_pkg::CHAR_W-1:0]   i_s_tdata,
    input  logic                           i_s_tlast,
    output logic                           o_push,
    output c128b_pkg::t_cmd                o_cmd,
    input  logic                           i_full
);
    import c128b_pkg::*;

    logic             r_in_message, n_in_message;
    logic [SYM_W-1:0] r_position, n_position;
    logic             r_discarding, n_discarding;

    logic              accept;
    logic              char_ok;
    logic [CHAR_W-1:0] offset;
    logic [SYM_W-1:0]  value;
    logic [SYM_W-1:0]  pos_use;
    logic [SYM_W-1:0]  pos_next;
    logic [PROD_W-1:0] prod;

    // requests are dropped without queueing while discarding
    assign o_s_tready = !i_full || r_discarding;
    assign accept     = i_s_tvalid && o_s_tready;

    assign char_ok  = i_s_tdata inside {[FIRST_VALID:LAST_VALID]};
    assign offset   = i_s_tdata - FIRST_VALID;
    assign value    = offset[SYM_W-1:0];
    assign pos_use  = r_in_message ? r_position : SYM_W'(1);
    assign pos_next = (pos_use == CHECK_MOD - SYM_W'(1)) ? '0 : pos_use + SYM_W'(1);
    assign prod     = {{(PROD_W-SYM_W){1'b0}}, pos_use} * {{(PROD_W-SYM_W){1'b0}}, value};

    assign o_push      = accept && !r_discarding;
    assign o_cmd.bad   = !char_ok;
    assign o_cmd.start = !r_in_message;
    assign o_cmd.last  = i_s_tlast;
    assign o_cmd.value = value;
    assign o_cmd.prod  = prod;

    always_comb begin
        n_in_message = r_in_message;
        n_position   = r_position;
        n_discarding = r_discarding;
        if (accept) begin
            if (r_discarding) begin
                if (i_s_tlast) begin
                    n_discarding = 1'b0;
                end
            end else if (!char_ok) begin
                n_in_message = 1'b0;
                n_position   = '0;
                n_discarding = !i_s_tlast;
            end else begin
                n_in_message = !i_s_tlast;
                n_position   = i_s_tlast ? '0 : pos_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_message <= 1'b0;
            r_position   <= '0;
            r_discarding <= 1'b0;
        end else begin
            r_in_message <= n_in_message;
            r_position   <= n_position;
            r_discarding <= n_discarding;
        end
    end

endmodule

// ----- rtl/c128b_queue.sv -----
`timescale 1ns / 1ps

module c128b_queue #(
    parameter int DEPTH = c128b_pkg::C128B_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  c128b_pkg::t_cmd i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output c128b_pkg::t_cmd o_data
);
    import c128b_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // front must hold off while the queue is full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

// ----- rtl/c128b_back.sv -----
`timescale 1ns / 1ps

module c128b_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  c128b_pkg::t_cmd               i_q_data,
    output logic                          o_q_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [c128b_pkg::OUT_W-1:0]   o_m_tdata,
    output logic                          o_m_tlast,
    output logic                          o_m_tuser
);
    import c128b_pkg::*;

    // restoring reduction, product stays below modulus shifted by SYM_W
    function automatic logic [SYM_W-1:0] reduce_mod(input logic [PROD_W-1:0] x);
        logic [PROD_W-1:0] r;
        r = x;
        for (int k = SYM_W - 1; k >= 0; k--) begin
            if (r >= (PROD_W'(CHECK_MOD) << k)) begin
                r = r - (PROD_W'(CHECK_MOD) << k);
            end
        end
        return r[SYM_W-1:0];
    endfunction

    t_cmd             r_cur;
    logic             r_cur_valid;
    logic [SYM_W-1:0] r_term;
    t_phase           r_phase, n_phase;
    logic [SYM_W-1:0] r_checksum, n_checksum;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;
    logic             r_out_bad;

    logic             out_load;
    logic             emit;
    logic             cur_done;
    logic             cur_take;
    logic [SYM_W:0]   sum_raw;
    logic [SYM_W-1:0] acc;
    logic [SYM_W-1:0] sym_value;
    logic             sym_final;
    logic             sym_bad;
    t_widths          sym_w;

    assign out_load = !r_out_valid || i_m_tready;
    assign emit     = r_cur_valid && out_load;
    assign cur_take = !r_cur_valid || (emit && cur_done);
    assign o_q_pop  = cur_take && i_q_valid;

    assign sum_raw = {1'b0, r_checksum} + {1'b0, r_term};
    assign acc     = (sum_raw >= {1'b0, CHECK_MOD}) ? SYM_W'(sum_raw - {1'b0, CHECK_MOD})
                                                     : sum_raw[SYM_W-1:0];

    // symbol selection for the current entry
    always_comb begin
        sym_value  = '0;
        sym_final  = 1'b0;
        sym_bad    = 1'b0;
        cur_done   = 1'b0;
        n_checksum = r_checksum;
        case (r_phase)
            PH_HEAD: begin
                if (r_cur.bad) begin
                    sym_bad   = 1'b1;
                    sym_final = 1'b1;
                    cur_done  = 1'b1;
                end else if (r_cur.start) begin
                    sym_value  = START_B;
                    n_checksum = START_SUM;
                end else begin
                    sym_value  = r_cur.value;
                    n_checksum = acc;
                    cur_done   = !r_cur.last;
                end
            end
            PH_DATA: begin
                sym_value  = r_cur.value;
                n_checksum = acc;
                cur_done   = !r_cur.last;
            end
            PH_CHECK: begin
                sym_value = r_checksum;
            end
            PH_STOP: begin
                sym_value = STOP_VAL;
                sym_final = 1'b1;
                cur_done  = 1'b1;
            end
            default: begin
                cur_done = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (emit) begin
            case (r_phase)
                PH_HEAD: begin
                    if (r_cur.bad) begin
                        n_phase = PH_HEAD;
                    end else if (r_cur.start) begin
                        n_phase = PH_DATA;
                    end else begin
                        n_phase = r_cur.last ? PH_CHECK : PH_HEAD;
                    end
                end
                PH_DATA:  n_phase = r_cur.last ? PH_CHECK : PH_HEAD;
                PH_CHECK: n_phase = PH_STOP;
                PH_STOP:  n_phase = PH_HEAD;
                default:  n_phase = PH_HEAD;
            endcase
        end
    end

    assign sym_w = sym_bad ? t_widths'('0) : symbol_widths(sym_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_phase     <= PH_HEAD;
            r_checksum  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cur_take) begin
                r_cur_valid <= i_q_valid;
            end
            r_phase <= n_phase;
            if (emit) begin
                r_checksum <= n_checksum;
            end
            if (out_load) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cur_take) begin
            r_cur  <= i_q_data;
            r_term <= reduce_mod(i_q_data.prod);
        end
        if (emit) begin
            r_out_data <= {{(OUT_W - SYM_W - 21){1'b0}}, sym_w.bar_d, sym_w.space_c,
                           sym_w.bar_c, sym_w.space_b, sym_w.bar_b, sym_w.space_a,
                           sym_w.bar_a, sym_value};
            r_out_last <= sym_final;
            r_out_bad  <= sym_bad;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_bad;

    a_bad_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("error result without end of run");

    a_check_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CHECK |-> r_cur_valid && r_cur.last && !r_cur.bad)
        else $error("check phase outside a final character");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_checksum < CHECK_MOD)
        else $error("checksum out of range");

endmodule

// ----- rtl/code128b_symbol_encoder.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] character, tlast end of message
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata symbol and widths, tlast final symbol,
//                                               tuser bad character
//
// a message character is accepted every cycle while the queue has room; the back sequencer
// sends one symbol per cycle from its output register while m_axis is not stalled, so a
// middle character gives one symbol, the first one two (start b then data) and the last
// one two more (check then stop); a request passes the queue, working entry and output
// reset is synchronous and clears all control state; no sweep is needed afterwards
// a stall on m_axis fills the queue and then drops s_axis_tready, except while the rest of
// an aborted message is being discarded, which needs no queue room

module code128b_symbol_encoder #(
    parameter int QUEUE_DEPTH = c128b_pkg::C128B_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] character
    input  logic [c128b_pkg::CHAR_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [6:0] symbol_value, [9:7] width_bar_a, [12:10] width_space_a, [15:13] width_bar_b,
    // [18:16] width_space_b, [21:19] width_bar_c, [24:22] width_space_c,
    // [27:25] width_bar_d, [31:28] zero
    output logic [c128b_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tlast,
    // [0] bad_character
    output logic [0:0]                    m_axis_tuser
);
    import c128b_pkg::*;

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;

    // queue to back
    logic q_valid;
    t_cmd q_data;
    logic q_pop;

    // front: classify characters, keep position and message state, form position times value
    c128b_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (q_full)
    );

    // short queue lets start, check and stop symbols go out without stalling the input
    c128b_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // back: reduce the weighted term, keep the checksum, sequence symbols and look up widths
    c128b_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser[0])
    );

endmodule
